[rtl/core/cloth_sag_vertex_displace_unit_macros.svh]
// Assertion macros shared by the cloth sag vertex displace RTL.
`ifndef CLOTH_SAG_VERTEX_DISPLACE_UNIT_MACROS_SVH
`define CLOTH_SAG_VERTEX_DISPLACE_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define CSV_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define CSV_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/csv_pkg.sv]
// Shared constants, types and lookup tables of the cloth sag vertex displace unit.
package csv_pkg;

    localparam int TRIG_BITS    = 10;
    localparam int TRIG_N       = 1 << TRIG_BITS;
    localparam int TRIG_Q       = TRIG_N / 4;
    localparam int SQRT_BITS    = 10;
    localparam int SQRT_N       = 1 << SQRT_BITS;
    localparam int SQRT_RND     = 1 << (15 - SQRT_BITS);
    localparam int SQRT_SHIFT   = 16 - SQRT_BITS;
    localparam longint PI_Q28   = 64'sd843314857;

    // x * N / 16 gives the sin(2 pi u) phase; y * 4096 gives v in Q12 after /h
    localparam int X_SCALE_BITS = TRIG_BITS - 4;
    localparam int V_FRAC_BITS  = 12;

    // long division lanes
    localparam int DIV_STEPS    = 30;
    localparam int DIV_MAG_W    = 30;
    localparam int DIV_NUM_W    = DIV_MAG_W + 1;
    localparam int DEN_W        = 14;
    localparam int LANE_DEPTH   = DIV_STEPS + 1;

    // pipeline bookkeeping
    localparam int PREP_DEPTH   = 4;
    localparam int DLY_DEPTH    = LANE_DEPTH - PREP_DEPTH;
    localparam int FIN_DEPTH    = 5;
    localparam int PIPE_DEPTH   = 1 + LANE_DEPTH + FIN_DEPTH;

    // fixed-point constants
    localparam int BREATH_BIAS  = 65536;
    localparam int DIV5_MUL     = 52429;
    localparam int DIV5_SHIFT   = 18;
    localparam int HALF_Q15     = 16384;
    localparam int ONE_Q14      = 16384;
    localparam int SQRT_K_MAX   = 7;
    localparam int SQRT_M_MAX   = 65536;

    localparam int IN_TDATA_W   = 88;
    localparam int OUT_TDATA_W  = 56;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAG_RATIO,
        CFG_CONTRACT_RATIO,
        CFG_SHADE_DEPTH,
        CFG_WAVE_RATE,
        CFG_SCREEN_WIDTH,
        CFG_SCREEN_HEIGHT
    } cfg_index_t;

    typedef struct packed {
        logic [15:0]      sag_ratio;
        logic [15:0]      contract_ratio;
        logic [15:0]      shade_depth;
        logic [15:0]      wave_rate;
        logic [DEN_W-1:0] width;
        logic [DEN_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic [30:0]        a_sag;
        logic [30:0]        a_con;
        logic [16:0]        a_sh;
    } side_t;

    typedef logic signed [15:0] sin_tab_t [TRIG_N];
    typedef logic [16:0] sqrt_tab_t [SQRT_N + 1];

    // unsigned shift-subtract quotient, table build only
    function automatic longint unsigned udiv_tab(input longint unsigned a,
                                                 input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin on [0, pi/2], Q28 in and out, Taylor series
    function automatic longint sine_q28(input longint x);
        longint x2;
        longint term;
        longint sum;
        longint n;
        x2   = (x * x) >>> 28;
        term = x;
        sum  = x;
        n    = 1;
        while (term != 0) begin
            term = longint'(udiv_tab(64'((term * x2) >>> 28),
                                     64'((2 * n) * (2 * n + 1))));
            if (n[0])
                sum = sum - term;
            else
                sum = sum + term;
            n = n + 1;
        end
        return (sum < 0) ? 64'sd0 : sum;
    endfunction

    function automatic longint quarter_sine(input longint j);
        longint s;
        s = (sine_q28(PI_Q28 * j / (2 * TRIG_Q)) + 8192) >>> 14;
        if (s > 16384)
            s = 16384;
        return s;
    endfunction

    function automatic sin_tab_t build_sin();
        sin_tab_t t;
        longint   quad;
        longint   j;
        longint   s;
        for (int i = 0; i < TRIG_N; i++) begin
            quad = i / TRIG_Q;
            j    = i % TRIG_Q;
            s    = quad[0] ? quarter_sine(TRIG_Q - j) : quarter_sine(j);
            if (quad >= 2)
                s = -s;
            t[i] = 16'(s);
        end
        return t;
    endfunction

    function automatic longint unsigned isqrt_round(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        longint unsigned m;
        r = 0;
        b = 64'd1 << 40;
        m = n;
        while (b > m)
            b = b >> 2;
        while (b != 0) begin
            if (m >= r + b) begin
                m = m - (r + b);
                r = (r >> 1) + b;
            end
            else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (n - r * r > r)
            r = r + 1;
        return r;
    endfunction

    function automatic sqrt_tab_t build_sqrt();
        sqrt_tab_t t;
        for (int i = 0; i <= SQRT_N; i++)
            t[i] = 17'(isqrt_round(64'(i) << (32 - SQRT_BITS)));
        return t;
    endfunction

    localparam sin_tab_t  SIN_TAB  = build_sin();
    localparam sqrt_tab_t SQRT_TAB = build_sqrt();

endpackage

[rtl/core/csv_div_lane.sv]
// Pipelined signed floor division, one quotient bit per stage.
module csv_div_lane (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [csv_pkg::DIV_NUM_W-1:0]  num,
    input  logic        [csv_pkg::DEN_W-1:0]      den,
    output logic signed [csv_pkg::DIV_NUM_W-1:0]  quo
);
    import csv_pkg::*;

    localparam int LAST = LANE_DEPTH - 1;

    logic [DEN_W-1:0]     rem_reg  [LANE_DEPTH];
    logic [DEN_W-1:0]     rem_next [LANE_DEPTH];
    logic [DIV_MAG_W-1:0] bits_reg  [LANE_DEPTH];
    logic [DIV_MAG_W-1:0] bits_next [LANE_DEPTH];
    logic [DEN_W-1:0]     den_reg  [LANE_DEPTH];
    logic [DEN_W-1:0]     den_next [LANE_DEPTH];
    logic                 neg_reg  [LANE_DEPTH];
    logic                 neg_next [LANE_DEPTH];
    logic [DEN_W:0]       trial    [DIV_STEPS];

    logic signed [DIV_NUM_W-1:0] neg_num;
    logic signed [DIV_NUM_W-1:0] q_mag;
    logic                        rnd;

    assign neg_num = -num;

    always_comb
    begin
        // stage 0 holds the magnitude; dividend bits shift out as quotient bits shift in
        rem_next[0]  = '0;
        bits_next[0] = num[DIV_NUM_W-1] ? neg_num[DIV_MAG_W-1:0] : num[DIV_MAG_W-1:0];
        den_next[0]  = den;
        neg_next[0]  = num[DIV_NUM_W-1];
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial[k]      = {rem_reg[k], bits_reg[k][DIV_MAG_W-1]};
            den_next[k+1] = den_reg[k];
            neg_next[k+1] = neg_reg[k];
            if (trial[k] >= {1'b0, den_reg[k]})
            begin
                rem_next[k+1]  = DEN_W'(trial[k] - {1'b0, den_reg[k]});
                bits_next[k+1] = {bits_reg[k][DIV_MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k+1]  = trial[k][DEN_W-1:0];
                bits_next[k+1] = {bits_reg[k][DIV_MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LANE_DEPTH; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                bits_reg[k] <= bits_next[k];
                den_reg[k]  <= den_next[k];
                neg_reg[k]  <= neg_next[k];
            end
        end
    end

    // floor for negative dividends: -(q + 1) when a remainder is left
    assign q_mag = signed'({1'b0, bits_reg[LAST]});
    assign rnd   = |rem_reg[LAST];
    assign quo   = neg_reg[LAST] ? -(q_mag + DIV_NUM_W'(rnd)) : q_mag;

endmodule

[rtl/core/csv_prep.sv]
// Time-phase tables and amplitude products, four stages ahead of the delay line.
module csv_prep (
    input  logic                                  clk,
    input  logic                                  en,
    input  csv_pkg::cfg_t                         cfg,
    input  logic        [csv_pkg::TRIG_BITS-1:0]  ph_idx,
    input  logic        [15:0]                    inten,
    input  logic signed [17:0]                    x,
    input  logic signed [17:0]                    y,
    output csv_pkg::side_t                        side
);
    import csv_pkg::*;

    logic [TRIG_BITS-1:0] cos_idx;

    // stage 1
    logic signed [15:0] st_reg;
    logic signed [15:0] ct_reg;
    logic [29:0]        msag1_reg;
    logic [29:0]        mcon1_reg;
    logic [16:0]        mshd1_reg;
    logic [15:0]        inten1_reg;
    logic signed [17:0] x1_reg;
    logic signed [17:0] y1_reg;

    // stage 2
    logic signed [17:0] bsum;
    logic signed [16:0] csum;
    logic [14:0]        breath2_reg;
    logic [15:0]        cterm2_reg;
    logic [29:0]        msag2_reg;
    logic [30:0]        acon2_reg;
    logic [16:0]        mshd2_reg;
    logic [15:0]        inten2_reg;
    logic signed [17:0] x2_reg;
    logic signed [17:0] y2_reg;

    // stage 3
    logic [29:0]        msag3_reg;
    logic [30:0]        acon3_reg;
    logic [16:0]        ash3_reg;
    logic [15:0]        inten3_reg;
    logic signed [17:0] x3_reg;
    logic signed [17:0] y3_reg;

    // stage 4
    side_t side_reg;

    assign cos_idx = ph_idx + TRIG_BITS'(TRIG_Q);
    assign bsum    = 18'sd65536 + 18'(st_reg);
    assign csum    = 17'sd16384 + 17'(ct_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg     <= SIN_TAB[ph_idx];
            ct_reg     <= SIN_TAB[cos_idx];
            msag1_reg  <= 30'(cfg.sag_ratio) * 30'(cfg.height);
            mcon1_reg  <= 30'(cfg.contract_ratio) * 30'(cfg.width);
            mshd1_reg  <= 17'((32'(cfg.shade_depth) * 32'(inten)) >> 15);
            inten1_reg <= inten;
            x1_reg     <= x;
            y1_reg     <= y;

            // 0.8 + 0.2 sin as (4 + sin) / 5 in Q14, divide by 5 via reciprocal
            breath2_reg <= 15'((35'(bsum[16:0]) * 35'(DIV5_MUL)) >> DIV5_SHIFT);
            cterm2_reg  <= csum[15:0];
            msag2_reg   <= msag1_reg;
            acon2_reg   <= 31'((46'(mcon1_reg) * 46'(inten1_reg)) >> 15);
            mshd2_reg   <= mshd1_reg;
            inten2_reg  <= inten1_reg;
            x2_reg      <= x1_reg;
            y2_reg      <= y1_reg;

            msag3_reg  <= 30'((45'(msag2_reg) * 45'(breath2_reg)) >> 14);
            acon3_reg  <= acon2_reg;
            ash3_reg   <= 17'((33'(mshd2_reg) * 33'(cterm2_reg)) >> 15);
            inten3_reg <= inten2_reg;
            x3_reg     <= x2_reg;
            y3_reg     <= y2_reg;

            side_reg.a_sag <= 31'((47'(msag3_reg) * 47'(inten3_reg)) >> 15);
            side_reg.a_con <= acon3_reg;
            side_reg.a_sh  <= ash3_reg;
            side_reg.x     <= x3_reg;
            side_reg.y     <= y3_reg;
        end
    end

    assign side = side_reg;

endmodule

[rtl/core/csv_finish.sv]
// Horizontal sines, square root and final products, ending in the output register.
module csv_finish (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic        [csv_pkg::TRIG_BITS:0]    qx_lo,
    input  logic signed [csv_pkg::DIV_NUM_W-1:0]  vq,
    input  csv_pkg::side_t                        side,
    output logic signed [17:0]                    out_x,
    output logic signed [17:0]                    out_y,
    output logic signed [17:0]                    shade
);
    import csv_pkg::*;

    function automatic logic signed [17:0] sat18(input logic signed [39:0] v);
        if (v > 40'sd131071)
            return 18'sd131071;
        else if (v < -40'sd131072)
            return -18'sd131072;
        else
            return v[17:0];
    endfunction

    // stage D
    logic [TRIG_BITS:0]          qx_d_reg;
    logic signed [DIV_NUM_W-1:0] vq_d_reg;
    side_t                       side_d_reg;

    // stage E
    logic [DIV_MAG_W-1:0] vpos;
    logic [2:0]           k_sel;
    logic [16:0]          m_red;
    logic [SQRT_BITS:0]   sqi_next;

    logic signed [15:0]          spu_e_reg;
    logic signed [15:0]          s2pu_e_reg;
    logic [SQRT_BITS:0]          sqi_e_reg;
    logic [2:0]                  sqk_e_reg;
    logic signed [DIV_NUM_W-1:0] vq_e_reg;
    side_t                       side_e_reg;

    // stage F
    logic signed [47:0]          prod_sag;
    logic signed [47:0]          prod_con;
    logic signed [33:0]          prod_sh;
    logic [23:0]                 sq_f_reg;
    logic signed [32:0]          psag_f_reg;
    logic signed [32:0]          pcon_f_reg;
    logic signed [18:0]          psh_f_reg;
    logic signed [DIV_NUM_W-1:0] vq_f_reg;
    logic signed [17:0]          x_f_reg;
    logic signed [17:0]          y_f_reg;

    // stage G
    logic signed [57:0] prod_dy;
    logic signed [63:0] prod_dx;
    logic signed [49:0] prod_shm;
    logic signed [31:0] dy_g_reg;
    logic signed [37:0] dxm_g_reg;
    logic signed [33:0] shm_g_reg;
    logic signed [17:0] x_g_reg;
    logic signed [17:0] y_g_reg;

    // stage H
    logic signed [17:0] out_x_reg;
    logic signed [17:0] out_y_reg;
    logic signed [17:0] shade_reg;

    // sqrt of v above 65536: shift down by 2k until at most 65536, table value up by k
    always_comb
    begin
        vpos  = (vq_d_reg > 0) ? vq_d_reg[DIV_MAG_W-1:0] : '0;
        k_sel = 3'(SQRT_K_MAX);
        for (int kk = SQRT_K_MAX - 1; kk >= 0; kk--)
        begin
            if ((vpos >> (2 * kk)) <= DIV_MAG_W'(SQRT_M_MAX))
                k_sel = 3'(kk);
        end
        m_red    = 17'(vpos >> (2 * k_sel));
        sqi_next = (SQRT_BITS + 1)'((18'(m_red) + 18'(SQRT_RND)) >> SQRT_SHIFT);
    end

    assign prod_sag = 48'(signed'({1'b0, side_e_reg.a_sag})) * 48'(spu_e_reg);
    assign prod_con = 48'(signed'({1'b0, side_e_reg.a_con})) * 48'(s2pu_e_reg);
    assign prod_sh  = 34'(signed'({1'b0, side_e_reg.a_sh})) * 34'(spu_e_reg);

    assign prod_dy  = 58'(psag_f_reg) * 58'(signed'({1'b0, sq_f_reg}));
    assign prod_dx  = 64'(pcon_f_reg) * 64'(vq_f_reg);
    assign prod_shm = 50'(psh_f_reg) * 50'(vq_f_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_d_reg   <= qx_lo;
            vq_d_reg   <= vq;
            side_d_reg <= side;

            // sin(pi u) uses floor(q/2), sin(2 pi u) uses q itself
            spu_e_reg  <= SIN_TAB[qx_d_reg[TRIG_BITS:1]];
            s2pu_e_reg <= SIN_TAB[qx_d_reg[TRIG_BITS-1:0]];
            sqi_e_reg  <= sqi_next;
            sqk_e_reg  <= k_sel;
            vq_e_reg   <= vq_d_reg;
            side_e_reg <= side_d_reg;

            sq_f_reg   <= 24'(SQRT_TAB[sqi_e_reg]) << sqk_e_reg;
            psag_f_reg <= 33'(prod_sag >>> 14);
            pcon_f_reg <= 33'(prod_con >>> 14);
            psh_f_reg  <= 19'(prod_sh >>> 14);
            vq_f_reg   <= vq_e_reg;
            x_f_reg    <= side_e_reg.x;
            y_f_reg    <= side_e_reg.y;

            dy_g_reg  <= 32'(prod_dy >>> 24);
            dxm_g_reg <= 38'(prod_dx >>> 24);
            shm_g_reg <= 34'(prod_shm >>> 14);
            x_g_reg   <= x_f_reg;
            y_g_reg   <= y_f_reg;

            out_x_reg <= sat18(40'(x_g_reg) - 40'(dxm_g_reg));
            out_y_reg <= sat18(40'(y_g_reg) + 40'(dy_g_reg));
            shade_reg <= sat18(40'(ONE_Q14) - 40'(shm_g_reg));
        end
    end

    assign out_x = out_x_reg;
    assign out_y = out_y_reg;
    assign shade = shade_reg;

endmodule

[rtl/core/cloth_sag_vertex_displace_unit.sv]
// Top level of the cloth sag vertex displace unit: config, pipeline control, lanes.
`include "cloth_sag_vertex_displace_unit_macros.svh"

// Cloth sag vertex displace unit. Takes one rest vertex per cycle and returns the
// displaced vertex and its shade factor, one result per input, in order. Most of
// the pipeline is the two 30-stage long division lanes (x / screen_width and
// y / screen_height, one quotient bit per stage) that run beside the sine,
// breathing and amplitude products. Throughput is one beat per cycle. A stall at
// the output freezes the whole pipe; s_tready drops only while the output register
// holds a beat that is not taken. Configuration writes take effect at once and
// belong in idle periods.
module cloth_sag_vertex_displace_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // rest_x[17:0], rest_y[35:18], frame_time[67:36], intensity[83:68], zero pad
    input  logic [csv_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_x[17:0], out_y[35:18], shade[53:36], zero pad
    output logic [csv_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_we,
    input  logic [csv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csv_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import csv_pkg::*;

    logic [15:0]      sag_reg;
    logic [15:0]      con_reg;
    logic [15:0]      shd_reg;
    logic [15:0]      rate_reg;
    logic [DEN_W-1:0] width_reg;
    logic [DEN_W-1:0] height_reg;
    cfg_t             cfg;

    logic                  en;
    logic [PIPE_DEPTH-1:0] valid_reg;

    logic signed [17:0]   rest_x;
    logic signed [17:0]   rest_y;
    logic [31:0]          frame_time;
    logic [15:0]          intensity;
    logic [23:0]          ph_next;

    logic signed [17:0]   x0_reg;
    logic signed [17:0]   y0_reg;
    logic [15:0]          inten0_reg;
    logic [TRIG_BITS-1:0] ph_idx0_reg;

    logic signed [DIV_NUM_W-1:0] num_x;
    logic signed [DIV_NUM_W-1:0] num_y;
    logic signed [DIV_NUM_W-1:0] quo_x;
    logic signed [DIV_NUM_W-1:0] quo_y;

    side_t prep_side;
    side_t dly_reg [DLY_DEPTH];

    logic signed [17:0] out_x;
    logic signed [17:0] out_y;
    logic signed [17:0] shade;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sag_reg    <= '0;
            con_reg    <= '0;
            shd_reg    <= '0;
            rate_reg   <= 16'd256;
            width_reg  <= 14'd1920;
            height_reg <= 14'd1080;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SAG_RATIO:      sag_reg    <= cfg_data;
                CFG_CONTRACT_RATIO: con_reg    <= cfg_data;
                CFG_SHADE_DEPTH:    shd_reg    <= cfg_data;
                CFG_WAVE_RATE:      rate_reg   <= cfg_data;
                CFG_SCREEN_WIDTH:   width_reg  <= cfg_data[DEN_W-1:0];
                CFG_SCREEN_HEIGHT:  height_reg <= cfg_data[DEN_W-1:0];
                default: ;
            endcase
        end
    end

    // zero screen size counts as one
    always_comb
    begin
        cfg.sag_ratio      = sag_reg;
        cfg.contract_ratio = con_reg;
        cfg.shade_depth    = shd_reg;
        cfg.wave_rate      = rate_reg;
        cfg.width          = (width_reg == '0) ? DEN_W'(1) : width_reg;
        cfg.height         = (height_reg == '0) ? DEN_W'(1) : height_reg;
    end

    // whole pipe moves together unless the output beat is stuck
    assign en       = !valid_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], s_tvalid};
    end

    assign rest_x     = s_tdata[17:0];
    assign rest_y     = s_tdata[35:18];
    assign frame_time = s_tdata[67:36];
    assign intensity  = s_tdata[83:68];

    // phase f * t keeps only the fraction of a cycle
    assign ph_next = 24'(40'(cfg.wave_rate) * 40'(frame_time[23:0]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg      <= rest_x;
            y0_reg      <= rest_y;
            inten0_reg  <= intensity;
            ph_idx0_reg <= ph_next[23 -: TRIG_BITS];
        end
    end

    assign num_x = DIV_NUM_W'(signed'({x0_reg, {X_SCALE_BITS{1'b0}}}));
    assign num_y = DIV_NUM_W'(signed'({y0_reg, {V_FRAC_BITS{1'b0}}}));

    csv_div_lane u_div_x (
        .clk (clk),
        .en  (en),
        .num (num_x),
        .den (cfg.width),
        .quo (quo_x)
    );

    csv_div_lane u_div_y (
        .clk (clk),
        .en  (en),
        .num (num_y),
        .den (cfg.height),
        .quo (quo_y)
    );

    csv_prep u_prep (
        .clk    (clk),
        .en     (en),
        .cfg    (cfg),
        .ph_idx (ph_idx0_reg),
        .inten  (inten0_reg),
        .x      (x0_reg),
        .y      (y0_reg),
        .side   (prep_side)
    );

    // hold the side values until the quotients come out
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= prep_side;
            for (int i = 1; i < DLY_DEPTH; i++)
                dly_reg[i] <= dly_reg[i-1];
        end
    end

    csv_finish u_finish (
        .clk   (clk),
        .en    (en),
        .qx_lo (quo_x[TRIG_BITS:0]),
        .vq    (quo_y),
        .side  (dly_reg[DLY_DEPTH-1]),
        .out_x (out_x),
        .out_y (out_y),
        .shade (shade)
    );

    assign m_tdata = {2'b00, shade, out_y, out_x};

    `CSV_ASSERT_IMP(a_ready_when_out_empty, !m_tvalid, s_tready, "input held off with empty output stage")
    `CSV_ASSERT_NXT(a_stall_freezes_pipe, !s_tready, $stable(valid_reg), "pipe moved during stall")
    `CSV_ASSERT_IMP(a_beat_balance, $past(rst_n), $countones(valid_reg) == $past($countones(valid_reg)) + $past(s_tvalid && s_tready) - $past(m_tvalid && m_tready), "beat lost or invented in pipe")

endmodule
